FILE: hw/rtl/wfg_pkg.sv
// wfg_pkg: shared types and constants of the window function generator
// covers register indexes, window type codes, the job record and the cosine table builder
// depends on nothing
`timescale 1ns / 1ps

package wfg_pkg;

   // register indexes on the csr port
   localparam logic [2:0] CSR_WINDOW_TYPE   = 3'd0;
   localparam logic [2:0] CSR_WINDOW_LENGTH = 3'd1;
   localparam logic [2:0] CSR_GAIN          = 3'd2;
   localparam logic [2:0] CSR_PHASE_STEP    = 3'd3;
   localparam logic [2:0] CSR_RAMP_STEP     = 3'd4;

   // window type codes
   localparam logic [2:0] WIN_RECT     = 3'd0;
   localparam logic [2:0] WIN_TRIANGLE = 3'd1;
   localparam logic [2:0] WIN_HAMMING  = 3'd2;
   localparam logic [2:0] WIN_HANN     = 3'd3;
   localparam logic [2:0] WIN_BLACKMAN = 3'd4;
   localparam logic [2:0] WIN_BHARRIS  = 3'd5;
   localparam logic [2:0] WIN_WELCH    = 3'd6;

   // register reset values
   localparam logic [2:0]  RST_WINDOW_TYPE   = WIN_HAMMING;
   localparam logic [16:0] RST_WINDOW_LENGTH = 17'd512;
   localparam logic [15:0] RST_GAIN          = 16'd4096;
   localparam logic [31:0] RST_PHASE_STEP    = 32'd8405024;
   localparam logic [23:0] RST_RAMP_STEP     = 24'd65536;

   // hard cap on the period length from the 16-bit position counter
   localparam int unsigned LEN_LIMIT = 65536;

   localparam int unsigned JOB_QUEUE_DEPTH = 4;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1073741824;

   typedef struct packed {
      logic [31:0] phase;
      logic [24:0] ramp;
      logic        last;
   } wfg_job_type;

   typedef struct packed {
      logic [2:0]  window_type;
      logic [15:0] gain;
   } wfg_back_cfg_type;

   // quarter-wave cosine entry k in Q1.16, only evaluated at elaboration
   function automatic logic [16:0] cos_entry(input int unsigned k, input int unsigned bits);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        t;
      logic signed [63:0] c;
      x  = (64'(k) * HALF_PI_Q30) >> bits;
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd90;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd56;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd30;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd12;
      c  = $signed(ONE_Q30) - $signed(((x2 * t) >> 30) / 64'd2);
      if (c < 0) begin
         c = 0;
      end
      return 17'((c + 64'sd8192) >>> 14);
   endfunction

endpackage

FILE: hw/rtl/wfg_stream_if.sv
// wfg_stream_if: valid/ready channels of the window function generator
// request channel carries the restart flag, response channel the coefficient and last flag
// depends on nothing
`timescale 1ns / 1ps

interface wfg_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface wfg_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [19:0] coefficient;
   logic               last;

   modport source (output valid, output coefficient, output last, input ready);
   modport sink   (input valid, input coefficient, input last, output ready);
endinterface

FILE: hw/rtl/wfg_front.sv
// wfg_front: configuration registers, position / phase / ramp state and item acceptance
// each accepted item leaves one job record for the back end
// depends on wfg_pkg and wfg_stream_if
`timescale 1ns / 1ps

module wfg_front
   import wfg_pkg::*;
#(
   parameter int unsigned MAX_LENGTH = 65536
) (
   input  logic             clock,
   input  logic             reset,
   wfg_req_if.sink          req_chan,
   input  logic             csr_wr_en,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_wdata,
   input  logic             queue_full,
   output logic             job_push,
   output wfg_job_type      job_data,
   output wfg_back_cfg_type back_cfg
);

   localparam int unsigned  CAP_INT = (MAX_LENGTH < LEN_LIMIT) ? MAX_LENGTH : LEN_LIMIT;
   localparam logic [16:0]  LEN_CAP = 17'(CAP_INT);

   logic [2:0]  window_type_ff;
   logic [16:0] window_length_ff;
   logic [15:0] gain_ff;
   logic [31:0] phase_step_ff;
   logic [23:0] ramp_step_ff;

   logic [15:0] pos_ff, pos_in;
   logic [31:0] phase_ff, phase_in;
   logic [24:0] ramp_ff, ramp_in;

   logic [16:0] len_eff;
   logic [15:0] pos_cur;
   logic [31:0] phase_cur;
   logic [24:0] ramp_cur;
   logic        wrap;
   logic [25:0] ramp_sum;

   assign len_eff   = (window_length_ff > LEN_CAP) ? LEN_CAP : window_length_ff;
   assign pos_cur   = req_chan.restart ? 16'd0 : pos_ff;
   assign phase_cur = req_chan.restart ? 32'd0 : phase_ff;
   assign ramp_cur  = req_chan.restart ? 25'd0 : ramp_ff;
   assign wrap      = ({1'b0, pos_cur} + 17'd1) >= len_eff;
   assign ramp_sum  = {1'b0, ramp_cur} + {2'b00, ramp_step_ff};

   assign req_chan.ready = !queue_full;
   assign job_push       = req_chan.valid && !queue_full;
   assign job_data       = '{phase: phase_cur, ramp: ramp_cur, last: wrap};
   assign back_cfg       = '{window_type: window_type_ff, gain: gain_ff};

   always_comb begin
      pos_in   = pos_ff;
      phase_in = phase_ff;
      ramp_in  = ramp_ff;
      if (job_push) begin
         if (wrap) begin
            pos_in   = '0;
            phase_in = '0;
            ramp_in  = '0;
         end else begin
            // ramp climbs over the first half, then falls, clamped at both ends
            if ({1'b0, pos_cur} < (len_eff >> 1)) begin
               ramp_in = ramp_sum[25] ? {25{1'b1}} : ramp_sum[24:0];
            end else begin
               ramp_in = (ramp_cur > {1'b0, ramp_step_ff}) ?
                         ramp_cur - {1'b0, ramp_step_ff} : 25'd0;
            end
            pos_in   = pos_cur + 16'd1;
            phase_in = phase_cur + phase_step_ff;
         end
      end
      // a new length starts the period over
      if (csr_wr_en && csr_index == CSR_WINDOW_LENGTH) begin
         pos_in   = '0;
         phase_in = '0;
         ramp_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_type_ff   <= RST_WINDOW_TYPE;
         window_length_ff <= RST_WINDOW_LENGTH;
         gain_ff          <= RST_GAIN;
         phase_step_ff    <= RST_PHASE_STEP;
         ramp_step_ff     <= RST_RAMP_STEP;
         pos_ff           <= '0;
         phase_ff         <= '0;
         ramp_ff          <= '0;
      end else begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         ramp_ff  <= ramp_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_WINDOW_TYPE: begin
                  window_type_ff <= csr_wdata[2:0];
               end
               CSR_WINDOW_LENGTH: begin
                  window_length_ff <= csr_wdata[16:0];
               end
               CSR_GAIN: begin
                  gain_ff <= csr_wdata[15:0];
               end
               CSR_PHASE_STEP: begin
                  phase_step_ff <= csr_wdata;
               end
               CSR_RAMP_STEP: begin
                  ramp_step_ff <= csr_wdata[23:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   a_wrap_clears: assert property (@(posedge clock) disable iff (reset)
      job_push && wrap |=> pos_ff == 16'd0 && phase_ff == 32'd0 && ramp_ff == 25'd0)
      else $error("state not cleared after period end");

endmodule

FILE: hw/rtl/wfg_job_fifo.sv
// wfg_job_fifo: short queue of job records between front and back
// depends on wfg_pkg
`timescale 1ns / 1ps

module wfg_job_fifo
   import wfg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  wfg_job_type push_data,
   input  logic        pop,
   output wfg_job_type pop_data,
   output logic        full,
   output logic        empty
);

   localparam int unsigned PTR_BITS = $clog2(JOB_QUEUE_DEPTH);
   localparam int unsigned CNT_BITS = $clog2(JOB_QUEUE_DEPTH + 1);
   localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(JOB_QUEUE_DEPTH);
   localparam logic [PTR_BITS-1:0] LAST_PTR  = PTR_BITS'(JOB_QUEUE_DEPTH - 1);

   wfg_job_type         slot_ff [JOB_QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [CNT_BITS-1:0] count_ff;

   assign full     = count_ff == DEPTH_CNT;
   assign empty    = count_ff == '0;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full job queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("pop from empty job queue");

endmodule

FILE: hw/rtl/wfg_back.sv
// wfg_back: coefficient sequencer with quarter-wave cosine rom, gain multiply and output register
// depends on wfg_pkg and wfg_stream_if
`timescale 1ns / 1ps

module wfg_back
   import wfg_pkg::*;
#(
   parameter int unsigned COS_TABLE_BITS = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  wfg_back_cfg_type back_cfg,
   input  logic             job_ready,
   input  wfg_job_type      job_data,
   output logic             job_pop,
   wfg_rsp_if.source        rsp_chan
);

   localparam int unsigned ROM_DEPTH = (1 << COS_TABLE_BITS) + 1;
   localparam int unsigned AW        = COS_TABLE_BITS + 1;
   localparam logic [AW-1:0] QUARTER = AW'(1 << COS_TABLE_BITS);

   typedef enum logic [2:0] {
      ST_IDLE, ST_RD1, ST_RD2, ST_RD3, ST_ACC3, ST_WIN, ST_GAIN, ST_OUT
   } state_type;

   state_type          state_ff;
   wfg_job_type        job_ff;
   logic signed [35:0] acc_ff, acc_in;
   logic [35:0]        sq_ff;
   logic signed [19:0] w_ff, w_in;
   logic signed [36:0] prod_ff;
   logic               out_valid_ff;
   logic signed [19:0] coef_ff;
   logic               last_ff;

   logic [16:0] cos_rom [ROM_DEPTH];
   logic [16:0] rom_q_ff;
   logic        neg_ff;

   logic [31:0]               phase2;
   logic [31:0]               phase3;
   logic [31:0]               sel_phase;
   logic [COS_TABLE_BITS-1:0] frac;
   logic [AW-1:0]             rom_addr;
   logic signed [17:0]        cos_val;
   logic [15:0]               ka, kb, kc, kd;
   logic signed [16:0]        kterm;
   logic signed [34:0]        term;
   logic signed [17:0]        welch_d;
   logic signed [35:0]        rnd;
   logic signed [36:0]        scaled;
   logic signed [19:0]        coef_sat;
   logic                      out_ok;

   for (genvar k = 0; k < ROM_DEPTH; k++) begin : g_rom
      assign cos_rom[k] = cos_entry(k, COS_TABLE_BITS);
   end

   // harmonics wrap mod 2^32 like the fundamental
   assign phase2 = {job_ff.phase[30:0], 1'b0};
   assign phase3 = job_ff.phase + phase2;

   always_comb begin
      unique case (state_ff)
         ST_RD2:  sel_phase = phase2;
         ST_RD3:  sel_phase = phase3;
         default: sel_phase = job_ff.phase;
      endcase
   end

   // odd quadrants read the table mirrored
   assign frac     = sel_phase[29 -: COS_TABLE_BITS];
   assign rom_addr = sel_phase[30] ? QUARTER - {1'b0, frac} : {1'b0, frac};

   always_ff @(posedge clock) begin
      rom_q_ff <= cos_rom[rom_addr];
      neg_ff   <= sel_phase[31] ^ sel_phase[30];
   end

   assign cos_val = neg_ff ? -$signed({1'b0, rom_q_ff}) : $signed({1'b0, rom_q_ff});

   always_comb begin
      unique case (back_cfg.window_type)
         WIN_HAMMING:  begin ka = 16'd35389; kb = 16'd30147; kc = 16'd0;    kd = 16'd0;   end
         WIN_HANN:     begin ka = 16'd32768; kb = 16'd32768; kc = 16'd0;    kd = 16'd0;   end
         WIN_BLACKMAN: begin ka = 16'd27525; kb = 16'd32768; kc = 16'd5243; kd = 16'd0;   end
         WIN_BHARRIS:  begin ka = 16'd23511; kb = 16'd32001; kc = 16'd9259; kd = 16'd765; end
         default:      begin ka = 16'd0;     kb = 16'd0;     kc = 16'd0;    kd = 16'd0;   end
      endcase
   end

   always_comb begin
      unique case (state_ff)
         ST_RD2:  kterm = -$signed({1'b0, kb});
         ST_RD3:  kterm = $signed({1'b0, kc});
         ST_ACC3: kterm = -$signed({1'b0, kd});
         default: kterm = '0;
      endcase
   end

   assign term   = kterm * cos_val;
   assign acc_in = (state_ff == ST_RD2) ?
                   $signed({4'b0000, ka, 16'h0000}) + 36'(term) : acc_ff + 36'(term);

   assign welch_d = $signed({1'b0, job_ff.phase[31:15]}) - 18'sd65536;
   assign rnd     = (acc_ff + 36'sd32768) >>> 16;

   always_comb begin
      unique case (back_cfg.window_type)
         WIN_RECT:     w_in = 20'sd65536;
         WIN_TRIANGLE: w_in = $signed({3'b000, job_ff.ramp[24:8]});
         WIN_HAMMING, WIN_HANN, WIN_BLACKMAN, WIN_BHARRIS: w_in = rnd[19:0];
         WIN_WELCH:    w_in = 20'sd65536 - $signed({3'b000, sq_ff[32:16]});
         default:      w_in = '0;
      endcase
   end

   assign scaled = (prod_ff + 37'sd2048) >>> 12;

   always_comb begin
      if (scaled > 37'sd524287) begin
         coef_sat = 20'sd524287;
      end else if (scaled < -37'sd524288) begin
         coef_sat = -20'sd524288;
      end else begin
         coef_sat = scaled[19:0];
      end
   end

   assign out_ok  = !out_valid_ff || rsp_chan.ready;
   assign job_pop = (state_ff == ST_IDLE) && job_ready;

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.coefficient = coef_ff;
   assign rsp_chan.last        = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_OUT && out_ok) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (job_ready) begin
                  job_ff   <= job_data;
                  state_ff <= ST_RD1;
               end
            end
            ST_RD1: begin
               sq_ff    <= 36'(welch_d * welch_d);
               state_ff <= ST_RD2;
            end
            ST_RD2: begin
               acc_ff   <= acc_in;
               state_ff <= ST_RD3;
            end
            ST_RD3: begin
               acc_ff   <= acc_in;
               state_ff <= ST_ACC3;
            end
            ST_ACC3: begin
               acc_ff   <= acc_in;
               state_ff <= ST_WIN;
            end
            ST_WIN: begin
               w_ff     <= w_in;
               state_ff <= ST_GAIN;
            end
            ST_GAIN: begin
               prod_ff  <= w_ff * $signed({1'b0, back_cfg.gain});
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               // wait here while the output register still holds an untaken item
               if (out_ok) begin
                  coef_ff  <= coef_sat;
                  last_ff  <= job_ff.last;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT && !out_ok |=> state_ff == ST_OUT && out_valid_ff)
      else $error("finished item dropped while output stalled");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> state_ff == ST_RD1 && !job_pop)
      else $error("job popped outside idle");

endmodule

FILE: hw/rtl/window_function_generator_top.sv
// window_function_generator_top: window coefficient generator top level
// front end, job queue and coefficient back end; depends on wfg_pkg and wfg_stream_if
//
//   channel   dir   handshake      payload
//   req_chan  in    valid/ready    restart
//   rsp_chan  out   valid/ready    coefficient (s Q4.16), last
//   csr_*     in    csr_wr_en      csr_index, csr_wdata
//
// the front end takes one item per cycle while the 4-entry job queue has room
// the back end works on one item at a time: one pop, three cosine rom reads through a
//   single registered port, window select, gain multiply and output load
// it takes no new job until the last one is loaded into the output register
// synchronous active-high reset restores the register defaults; no clearing pass
// a stalled rsp_chan holds the back end in its output step; req_chan stalls once the queue fills
`timescale 1ns / 1ps

module window_function_generator_top
   import wfg_pkg::*;
#(
   parameter int unsigned MAX_LENGTH     = 65536,
   parameter int unsigned COS_TABLE_BITS = 10
) (
   input  logic        clock,
   input  logic        reset,
   wfg_req_if.sink     req_chan,
   wfg_rsp_if.source   rsp_chan,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic             queue_full;
   logic             queue_empty;
   logic             job_push;
   logic             job_pop;
   wfg_job_type      push_job;
   wfg_job_type      pop_job;
   wfg_back_cfg_type back_cfg;

   wfg_front #(
      .MAX_LENGTH (MAX_LENGTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .queue_full (queue_full),
      .job_push   (job_push),
      .job_data   (push_job),
      .back_cfg   (back_cfg)
   );

   wfg_job_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_job),
      .pop       (job_pop),
      .pop_data  (pop_job),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   wfg_back #(
      .COS_TABLE_BITS (COS_TABLE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .back_cfg  (back_cfg),
      .job_ready (!queue_empty),
      .job_data  (pop_job),
      .job_pop   (job_pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

FILE: tb/testbench.sv
// testbench: self-checking bench for window_function_generator_top
// predicts each coefficient and last flag from a software copy of the window state
// depends on wfg_pkg, wfg_stream_if and the top level
`timescale 1ns / 1ps

module testbench
   import wfg_pkg::*;
();

   localparam int unsigned TABLE_BITS     = 10;
   localparam int unsigned TABLE_FULL     = 1 << TABLE_BITS;
   localparam int unsigned PERIOD_CAP     = 65536;
   localparam int unsigned RAMP_TOP       = 32'h1FF_FFFF;
   localparam logic [63:0] HALF_PI_FIX    = 64'd1686629713;
   localparam logic [63:0] ONE_FIX        = 64'd1073741824;
   localparam logic [2:0]  WIN_UNDEFINED  = 3'd7;
   localparam int          RANDOM_TARGET  = 1700;
   localparam int          SETTLE_CYCLES  = 12;
   localparam int          END_CYCLES     = 24;
   localparam int          LONG_HOLD      = 200;
   localparam int          WATCHDOG_LIMIT = 3000;
   localparam int          MAX_REPORTS    = 100;

   typedef struct packed {
      logic signed [19:0] coefficient;
      logic               last;
   } window_sample_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   wfg_req_if req_chan ();
   wfg_rsp_if rsp_chan ();

   window_function_generator_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // software copy of the registers and the window state
   logic [2:0]  cfg_type;
   int unsigned cfg_length;
   int unsigned cfg_gain;
   logic [31:0] cfg_phase_step;
   int unsigned cfg_ramp_step;
   int unsigned win_position;
   logic [31:0] phase_acc;
   int unsigned ramp_acc;
   longint      cos_q16 [0:TABLE_FULL];

   logic              restart_backlog [$];
   window_sample_type pending_coefficients [$];
   window_sample_type oldest;

   int sender_idle_max   = 9;
   int receiver_idle_max = 9;
   int sender_wait;
   int receiver_wait;
   bit hold_off_req = 1'b0;
   bit hold_taken   = 1'b0;
   int quiet_cycles = 0;
   int fail_count   = 0;
   int items_accepted = 0;
   int results_checked = 0;
   int periods_closed = 0;
   int settings_used = 0;

   function automatic longint cosine_of(input logic [31:0] ph);
      int unsigned idx;
      idx = (ph >> (30 - TABLE_BITS)) & (TABLE_FULL - 1);
      case (ph[31:30])
         2'd0:    return cos_q16[idx];
         2'd1:    return -cos_q16[TABLE_FULL - idx];
         2'd2:    return -cos_q16[idx];
         default: return cos_q16[TABLE_FULL - idx];
      endcase
   endfunction

   // a - b cos(x) + c cos(2x) - d cos(3x), Q32 sum rounded to Q16
   function automatic longint cosine_blend(input longint a, input longint b,
                                           input longint c, input longint d);
      logic [31:0] ph2;
      logic [31:0] ph3;
      longint      s;
      ph2 = phase_acc << 1;
      ph3 = phase_acc * 32'd3;
      s = a * 65536 - b * cosine_of(phase_acc) + c * cosine_of(ph2) - d * cosine_of(ph3);
      return (s + 32768) >>> 16;
   endfunction

   function automatic void predict_window_sample(input logic restart);
      int unsigned       eff_len;
      int unsigned       ramp_sum;
      longint            w;
      longint            centered;
      longint            scaled;
      window_sample_type outcome;
      eff_len = (cfg_length > PERIOD_CAP) ? PERIOD_CAP : cfg_length;
      if (restart) begin
         win_position = 0;
         phase_acc = '0;
         ramp_acc = 0;
      end
      case (cfg_type)
         WIN_RECT:     w = 65536;
         WIN_TRIANGLE: w = longint'(ramp_acc >> 8);
         WIN_HAMMING:  w = cosine_blend(35389, 30147, 0, 0);
         WIN_HANN:     w = cosine_blend(32768, 32768, 0, 0);
         WIN_BLACKMAN: w = cosine_blend(27525, 32768, 5243, 0);
         WIN_BHARRIS:  w = cosine_blend(23511, 32001, 9259, 765);
         WIN_WELCH: begin
            centered = longint'(phase_acc >> 15) - 65536;
            w = 65536 - ((centered * centered) >>> 16);
         end
         default:      w = 0;
      endcase
      scaled = (w * longint'(cfg_gain) + 2048) >>> 12;
      if (scaled > 524287) begin
         scaled = 524287;
      end else if (scaled < -524288) begin
         scaled = -524288;
      end
      outcome.coefficient = scaled[19:0];
      outcome.last = (win_position + 1 >= eff_len);
      if (outcome.last) begin
         win_position = 0;
         phase_acc = '0;
         ramp_acc = 0;
      end else begin
         if (win_position < eff_len / 2) begin
            ramp_sum = ramp_acc + cfg_ramp_step;
            ramp_acc = (ramp_sum > RAMP_TOP) ? RAMP_TOP : ramp_sum;
         end else begin
            ramp_acc = (ramp_acc > cfg_ramp_step) ? ramp_acc - cfg_ramp_step : 0;
         end
         win_position = (win_position + 1) & 32'hFFFF;
         phase_acc = phase_acc + cfg_phase_step;
      end
      pending_coefficients.push_back(outcome);
   endfunction

   function automatic logic [31:0] cosine_step(input int unsigned len);
      return (len > 1) ? 32'((64'd1 << 32) / (len - 1)) : 32'd0;
   endfunction

   function automatic logic [23:0] triangle_step(input int unsigned len);
      longint q;
      q = (len >= 2) ? (longint'(1) << 24) / (len / 2) : 0;
      return (q > 24'hFF_FFFF) ? 24'hFF_FFFF : 24'(q);
   endfunction

   // random bits above the field so the write path has to mask them
   function automatic logic [31:0] pad_noise(input logic [31:0] v, input int width);
      return (v & ((32'd1 << width) - 1)) | ($urandom << width);
   endfunction

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_WINDOW_TYPE: cfg_type = value[2:0];
         CSR_WINDOW_LENGTH: begin
            cfg_length = value[16:0];
            win_position = 0;
            phase_acc = '0;
            ramp_acc = 0;
         end
         CSR_GAIN:        cfg_gain = value[15:0];
         CSR_PHASE_STEP:  cfg_phase_step = value;
         CSR_RAMP_STEP:   cfg_ramp_step = value[23:0];
         default: ;
      endcase
   endtask

   // with every_reg clear each register is written only with a chance of three in four
   task automatic program_window(input logic [2:0] wtype, input int unsigned len,
                                 input int unsigned g, input logic [31:0] pstep,
                                 input logic [23:0] rstep, input bit every_reg);
      if (every_reg || $urandom_range(0, 3) != 0) csr_write(CSR_WINDOW_TYPE, pad_noise(wtype, 3));
      if (every_reg || $urandom_range(0, 3) != 0) csr_write(CSR_WINDOW_LENGTH, pad_noise(len, 17));
      if (every_reg || $urandom_range(0, 3) != 0) csr_write(CSR_GAIN, pad_noise(g, 16));
      if (every_reg || $urandom_range(0, 3) != 0) csr_write(CSR_PHASE_STEP, pstep);
      if (every_reg || $urandom_range(0, 3) != 0) csr_write(CSR_RAMP_STEP, pad_noise(rstep, 24));
      settings_used++;
   endtask

   task automatic queue_restarts(input int count, input int restart_pct);
      for (int i = 0; i < count; i++) begin
         restart_backlog.push_back($urandom_range(0, 99) < restart_pct);
      end
   endtask

   // sampled on the falling edge so the driver's updates have settled
   task automatic drain();
      while (restart_backlog.size() != 0 || req_chan.valid
             || pending_coefficients.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // driver: one item from the backlog at a time, random gap before the next
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.restart <= 1'b0;
         sender_wait = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            predict_window_sample(req_chan.restart);
            items_accepted++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (sender_wait > 0) begin
               req_chan.valid <= 1'b0;
               sender_wait--;
            end else if (restart_backlog.size() != 0) begin
               req_chan.valid <= 1'b1;
               req_chan.restart <= restart_backlog.pop_front();
               sender_wait = $urandom_range(0, sender_idle_max);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each item against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         receiver_wait = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_checked++;
            if (rsp_chan.last) periods_closed++;
            if (pending_coefficients.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS) begin
                  $display("%0t ns unexpected item: expected none, %s %0d last %0b",
                           $time, "actual coefficient", rsp_chan.coefficient,
                           rsp_chan.last);
               end
            end else begin
               oldest = pending_coefficients.pop_front();
               if (rsp_chan.coefficient !== oldest.coefficient) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS) begin
                     $display("%0t ns coefficient mismatch: expected %0d, actual %0d",
                              $time, oldest.coefficient, rsp_chan.coefficient);
                  end
               end
               if (rsp_chan.last !== oldest.last) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS) begin
                     $display("%0t ns last mismatch: expected %0b, actual %0b",
                              $time, oldest.last, rsp_chan.last);
                  end
               end
            end
            receiver_wait = $urandom_range(0, receiver_idle_max);
         end
         if (hold_off_req && !hold_taken) begin
            receiver_wait = LONG_HOLD;
            hold_taken = 1'b1;
         end
         if (receiver_wait > 0) begin
            rsp_chan.ready <= 1'b0;
            receiver_wait--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || csr_wr_en) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("%0t ns watchdog: no handshake for %0d cycles", $time, quiet_cycles);
      $display("status: fail");
      $finish;
   end

   initial begin
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      longint      c;
      int          divisors [4];
      int          random_items;
      int          kind;
      int          count;
      int          restart_pct;
      int unsigned len;
      int unsigned g;
      logic [2:0]  wtype;
      logic [31:0] pstep;
      logic [23:0] rstep;

      divisors = '{90, 56, 30, 12};
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.restart = 1'b0;
      rsp_chan.ready = 1'b0;

      // quarter-wave cosine, Q30 Taylor series rounded to Q16
      for (int k = 0; k <= TABLE_FULL; k++) begin
         x = (64'(k) * HALF_PI_FIX) >> TABLE_BITS;
         x2 = (x * x) >> 30;
         t = ONE_FIX;
         foreach (divisors[j]) t = ONE_FIX - ((x2 * t) >> 30) / 64'(divisors[j]);
         c = longint'(ONE_FIX) - longint'(((x2 * t) >> 30) / 64'd2);
         if (c < 0) c = 0;
         cos_q16[k] = (c + 8192) >>> 14;
      end

      cfg_type = RST_WINDOW_TYPE;
      cfg_length = RST_WINDOW_LENGTH;
      cfg_gain = RST_GAIN;
      cfg_phase_step = RST_PHASE_STEP;
      cfg_ramp_step = RST_RAMP_STEP;
      win_position = 0;
      phase_acc = '0;
      ramp_acc = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // register defaults straight out of reset, then a restart
      restart_backlog.push_back(1'b0);
      restart_backlog.push_back(1'b0);
      restart_backlog.push_back(1'b1);
      drain();

      // unmapped register indexes are ignored, undefined type gives zero
      for (int i = int'(CSR_RAMP_STEP) + 1; i < 8; i++) csr_write(3'(i), $urandom);
      program_window(WIN_UNDEFINED, 512, 65535, cosine_step(512), triangle_step(512), 1'b1);
      queue_restarts(2, 0);
      drain();

      // zero length: every item ends a period; rect at full gain saturates
      program_window(WIN_RECT, 0, 65535, 32'd0, 24'd0, 1'b1);
      restart_backlog.push_back(1'b0);
      restart_backlog.push_back(1'b1);
      drain();

      program_window(WIN_WELCH, 1, 4096, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b1);
      queue_restarts(1, 0);
      drain();

      // ramp hits its top then its floor, coefficient saturates high
      program_window(WIN_TRIANGLE, 8, 65535, cosine_step(8), 24'hFF_FFFF, 1'b1);
      queue_restarts(8, 0);
      drain();

      // quarter-cycle steps land on every quadrant boundary
      program_window(WIN_BLACKMAN, 4, 4096, 32'h4000_0000, triangle_step(4), 1'b1);
      queue_restarts(4, 0);
      drain();

      // length beyond the cap, full-scale phase step
      program_window(WIN_BHARRIS, 131071, 8192, 32'hFFFF_FFFF, 24'd0, 1'b1);
      queue_restarts(3, 0);
      drain();

      program_window(WIN_HANN, 2, 0, cosine_step(2), triangle_step(2), 1'b1);
      queue_restarts(2, 0);
      drain();

      // receiver holds off while the sender keeps offering back to back
      sender_idle_max = 0;
      receiver_idle_max = 0;
      program_window(WIN_HANN, 16, 4096, cosine_step(16), triangle_step(16), 1'b1);
      hold_off_req = 1'b1;
      queue_restarts(40, 0);
      drain();
      hold_off_req = 1'b0;

      random_items = 0;
      while (random_items < RANDOM_TARGET) begin
         kind = $urandom_range(0, 9);
         wtype = ($urandom_range(0, 15) == 0) ? WIN_UNDEFINED : 3'($urandom_range(0, 6));
         case ($urandom_range(0, 5))
            0:       g = 0;
            1:       g = 65535;
            2:       g = 4096;
            default: g = $urandom_range(0, 65535);
         endcase
         if (kind < 7) begin
            // proper window with a few periods
            len = $urandom_range(2, 48);
            pstep = cosine_step(len);
            rstep = triangle_step(len);
            count = 2 * len + $urandom_range(0, len);
            restart_pct = 2;
         end else if (kind < 9) begin
            // arbitrary steps and lengths, frequent restarts
            len = $urandom_range(0, 1) ? $urandom_range(0, 300) : $urandom_range(0, 131071);
            pstep = $urandom;
            rstep = 24'($urandom);
            count = $urandom_range(5, 60);
            restart_pct = 20;
         end else begin
            len = $urandom_range(100, 400);
            pstep = cosine_step(len);
            rstep = triangle_step(len);
            count = len + $urandom_range(1, 8);
            restart_pct = 0;
         end
         sender_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
         receiver_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
         program_window(wtype, len, g, pstep, rstep, $urandom_range(0, 3) != 0);
         queue_restarts(count, restart_pct);
         random_items += count;
         drain();
      end

      repeat (END_CYCLES) @(posedge clock);
      $display("covered %0d items over %0d window settings, %0d period ends seen",
               items_accepted, settings_used, periods_closed);
      $display("%0d results compared, %0d mismatches", results_checked, fail_count);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
